// ----- sv/vertex_tangent_accumulator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Vertex tangent accumulator assertion macros
// Concurrent property macros clocked by i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TANGENT_ACCUMULATOR_TOP_ASSERT_SVH
`define VERTEX_TANGENT_ACCUMULATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vertex tangent accumulator: assertion failed");

// Next-cycle implication.
`define VTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vertex tangent accumulator: assertion failed");

`else

`define VTA_ASSERT_IMP(lbl, ante, cons)
`define VTA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/vta_pkg.sv -----
// ----------------------------------------------------------------------------
// Vertex tangent accumulator package
// Shared widths, codes and the command and status types between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package vta_pkg;

    localparam int VTA_MAX_VERTICES = 4096;
    localparam int S_TDATA_W        = 152;
    localparam int M_TDATA_W        = 64;

    // Item opcodes.
    localparam logic [1:0] OPC_CORNER = 2'd0;
    localparam logic [1:0] OPC_READ   = 2'd1;
    localparam logic [1:0] OPC_CLEAR  = 2'd2;

    // Corner codes that matter.
    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    // Result kinds.
    localparam logic KIND_FACE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        DP_NONE,
        DP_LOAD,
        DP_HOLD,
        DP_MUL_DET_A,
        DP_MUL_DET_B,
        DP_DET,
        DP_MUL_VEC_A,
        DP_MUL_VEC_B,
        DP_VEC,
        DP_NRM_FACE,
        DP_NRM_READ,
        DP_NRM_SHIFT,
        DP_MUL_SQ,
        DP_SQ_ACC,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_DONE,
        DP_ACC_RD,
        DP_ACC_WR,
        DP_VTX_RD,
        DP_CLEAR,
        DP_SWEEP,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] lane;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] corner;
        logic       det_zero;
        logic       mag_zero;
        logic       nrm_hi;
        logic       nrm_lo;
        logic       sweep_last;
    } t_dp_stat;

endpackage

// ----- sv/vta_datapath.sv -----
// ----------------------------------------------------------------------------
// Vertex tangent accumulator datapath
// Input and corner holding registers, the shared multiplier, the normalizer
// (shift, square root, divider), the tangent sum memory and the result word.
// ----------------------------------------------------------------------------
module vta_datapath
    import vta_pkg::*;
#(
    parameter int MAX_VERTICES = VTA_MAX_VERTICES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [S_TDATA_W-1:0] i_tdata,
    input  logic [1:0]           i_tuser,
    output t_dp_stat             o_stat,
    output logic [M_TDATA_W-1:0] o_tdata,
    output logic                 o_tuser
);

    localparam int              AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [16:0]     MAXV = 17'(MAX_VERTICES);
    localparam logic [AW-1:0]   LAST = AW'(MAX_VERTICES - 1);

    // Latched input word.
    logic        [1:0]  r_opc;
    logic        [1:0]  r_corner;
    logic        [11:0] r_idx;
    logic signed [31:0] r_pos [3];
    logic signed [19:0] r_tu;
    logic signed [19:0] r_tv;

    // Held corners 0 and 1.
    logic signed [31:0] r_hp0 [3];
    logic signed [31:0] r_hp1 [3];
    logic signed [19:0] r_hu  [2];
    logic signed [19:0] r_hv  [2];
    logic        [11:0] r_hidx [2];

    // Arithmetic registers.
    logic signed [67:0] r_prod;
    logic signed [67:0] r_tmp;
    logic               r_det_zero;
    logic               r_det_neg;
    logic signed [55:0] r_vec [3];
    logic        [55:0] r_mag [3];
    logic        [2:0]  r_neg;
    logic        [63:0] r_sq;
    logic        [63:0] r_sn;
    logic        [63:0] r_sr;
    logic        [63:0] r_sb;
    logic        [49:0] r_rem;
    logic        [49:0] r_dsh;
    logic        [17:0] r_q;
    logic signed [15:0] r_tan [3];

    // Sum memory and its access registers.
    logic        [71:0]   r_mem [MAX_VERTICES];
    logic        [71:0]   r_rdata;
    logic        [AW-1:0] r_wa;
    logic                 r_wok;
    logic                 r_rd_ok;
    logic        [AW-1:0] r_sweep;

    // Result word.
    logic [M_TDATA_W-1:0] r_o_tdata;
    logic                 r_o_tuser;

    function automatic logic [AW-1:0] f_addr(input logic [11:0] idx);
        logic [AW+11:0] w;
        w = {{AW{1'b0}}, idx};
        return w[AW-1:0];
    endfunction

    function automatic logic f_ok(input logic [11:0] idx);
        return {5'b0, idx} < MAXV;
    endfunction

    function automatic logic [23:0] f_sat(input logic [23:0] s, input logic [15:0] t);
        logic signed [24:0] w;
        w = 25'($signed(s)) + 25'($signed(t));
        if (w > 25'sd8388607) begin
            return 24'h7FFFFF;
        end else if (w < -25'sd8388608) begin
            return 24'h800000;
        end
        return w[23:0];
    endfunction

    // UV deltas and edges.
    logic signed [20:0] w_d1u, w_d1v, w_d2u, w_d2v;
    logic signed [32:0] w_e1 [3];
    logic signed [32:0] w_e2 [3];

    assign w_d1u = 21'(r_hu[1]) - 21'(r_hu[0]);
    assign w_d1v = 21'(r_hv[1]) - 21'(r_hv[0]);
    assign w_d2u = 21'(r_tu) - 21'(r_hu[0]);
    assign w_d2v = 21'(r_tv) - 21'(r_hv[0]);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_e1[j] = 33'(r_hp1[j]) - 33'(r_hp0[j]);
            w_e2[j] = 33'(r_pos[j]) - 33'(r_hp0[j]);
        end
    end

    // Shared multiplier operand selection.
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic signed [67:0] w_diff;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            DP_MUL_DET_A: begin
                w_ma = 34'(w_d1u);
                w_mb = 34'(w_d2v);
            end
            DP_MUL_DET_B: begin
                w_ma = 34'(w_d2u);
                w_mb = 34'(w_d1v);
            end
            DP_MUL_VEC_A: begin
                w_ma = 34'(w_d2v);
                w_mb = 34'(w_e1[i_cmd.lane]);
            end
            DP_MUL_VEC_B: begin
                w_ma = 34'(w_d1v);
                w_mb = 34'(w_e2[i_cmd.lane]);
            end
            DP_MUL_SQ: begin
                w_ma = {4'b0, r_mag[i_cmd.lane][29:0]};
                w_mb = {4'b0, r_mag[i_cmd.lane][29:0]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_diff = r_tmp - r_prod;

    // Square root step and divider step terms.
    logic [63:0] w_strial;
    logic        w_dge;
    logic [15:0] w_qc;
    logic [23:0] w_rs [3];

    assign w_strial = r_sr + r_sb;
    assign w_dge    = r_rem >= r_dsh;
    assign w_qc     = (r_q > 18'd32767) ? 16'd32767 : r_q[15:0];
    assign w_rs[0]  = r_rdata[23:0];
    assign w_rs[1]  = r_rdata[47:24];
    assign w_rs[2]  = r_rdata[71:48];

    // Memory port selection.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [71:0]   w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [11:0]   w_acc_idx;

    always_comb begin
        case (i_cmd.lane)
            2'd0:    w_acc_idx = r_hidx[0];
            2'd1:    w_acc_idx = r_hidx[1];
            default: w_acc_idx = r_idx;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wa;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = f_addr(r_idx);
        case (i_cmd.op)
            DP_ACC_RD: begin
                w_re    = 1'b1;
                w_raddr = f_addr(w_acc_idx);
            end
            DP_VTX_RD: begin
                w_re = 1'b1;
            end
            DP_ACC_WR: begin
                w_we    = r_wok;
                w_wdata = {f_sat(w_rs[2], r_tan[2]), f_sat(w_rs[1], r_tan[1]),
                           f_sat(w_rs[0], r_tan[0])};
            end
            DP_CLEAR: begin
                w_we    = f_ok(r_idx);
                w_waddr = f_addr(r_idx);
            end
            DP_SWEEP: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // Clearing sweep pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.op == DP_SWEEP) begin
            r_sweep <= r_sweep + AW'(1);
        end
    end

    // Datapath registers, one operation per cycle.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_opc    <= i_tuser;
                r_corner <= i_tdata[1:0];
                r_idx    <= i_tdata[13:2];
                r_pos[0] <= i_tdata[45:14];
                r_pos[1] <= i_tdata[77:46];
                r_pos[2] <= i_tdata[109:78];
                r_tu     <= i_tdata[129:110];
                r_tv     <= i_tdata[149:130];
            end
            DP_HOLD: begin
                if (r_corner == CORNER_0) begin
                    r_hp0     <= r_pos;
                    r_hu[0]   <= r_tu;
                    r_hv[0]   <= r_tv;
                    r_hidx[0] <= r_idx;
                end else begin
                    r_hp1     <= r_pos;
                    r_hu[1]   <= r_tu;
                    r_hv[1]   <= r_tv;
                    r_hidx[1] <= r_idx;
                end
            end
            DP_MUL_DET_A, DP_MUL_VEC_A, DP_MUL_SQ: begin
                r_prod <= w_prod;
            end
            DP_MUL_DET_B, DP_MUL_VEC_B: begin
                r_prod <= w_prod;
                r_tmp  <= r_prod;
            end
            DP_DET: begin
                r_det_zero <= (w_diff == '0);
                r_det_neg  <= w_diff[67];
            end
            DP_VEC: begin
                r_vec[i_cmd.lane] <= r_det_neg ? -w_diff[55:0] : w_diff[55:0];
            end
            DP_NRM_FACE: begin
                for (int j = 0; j < 3; j++) begin
                    r_neg[j] <= r_vec[j][55];
                    r_mag[j] <= r_vec[j][55] ? 56'(-r_vec[j]) : 56'(r_vec[j]);
                end
                r_sq <= '0;
            end
            DP_NRM_READ: begin
                for (int j = 0; j < 3; j++) begin
                    r_neg[j] <= w_rs[j][23];
                    if (!r_rd_ok) begin
                        r_mag[j] <= '0;
                    end else if (w_rs[j][23]) begin
                        r_mag[j] <= 56'(-$signed(w_rs[j]));
                    end else begin
                        r_mag[j] <= 56'(w_rs[j]);
                    end
                end
                r_sq <= '0;
            end
            DP_NRM_SHIFT: begin
                for (int j = 0; j < 3; j++) begin
                    if (o_stat.nrm_hi) begin
                        r_mag[j] <= r_mag[j] >> 1;
                    end else begin
                        r_mag[j] <= r_mag[j] << 1;
                    end
                end
            end
            DP_SQ_ACC: begin
                r_sq <= r_sq + r_prod[63:0];
            end
            DP_SQRT_INIT: begin
                r_sn <= r_sq;
                r_sr <= '0;
                r_sb <= 64'h4000_0000_0000_0000;
            end
            DP_SQRT_STEP: begin
                if (r_sn >= w_strial) begin
                    r_sn <= r_sn - w_strial;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            DP_DIV_INIT: begin
                r_rem <= 50'({r_mag[i_cmd.lane][29:0], 16'b0}) + 50'(r_sr[31:0]);
                r_dsh <= {r_sr[31:0], 18'b0};
                r_q   <= '0;
            end
            DP_DIV_STEP: begin
                if (w_dge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= {r_q[16:0], w_dge};
            end
            DP_DIV_DONE: begin
                r_tan[i_cmd.lane] <= r_neg[i_cmd.lane] ? -w_qc : w_qc;
            end
            DP_ACC_RD: begin
                r_wa  <= f_addr(w_acc_idx);
                r_wok <= f_ok(w_acc_idx);
            end
            DP_VTX_RD: begin
                r_rd_ok <= f_ok(r_idx);
            end
            DP_OUT: begin
                if (r_opc == OPC_READ) begin
                    r_o_tuser <= KIND_READ;
                    if (o_stat.mag_zero) begin
                        r_o_tdata <= {2'b0, 1'b1, 16'd0, 16'd0, 16'd32767, r_idx, 1'b0};
                    end else begin
                        r_o_tdata <= {2'b0, 1'b0, r_tan[2], r_tan[1], r_tan[0], r_idx, 1'b0};
                    end
                end else begin
                    r_o_tuser <= KIND_FACE;
                    r_o_tdata <= {63'd0, r_det_zero};
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_stat.opcode     = r_opc;
        o_stat.corner     = r_corner;
        o_stat.det_zero   = r_det_zero;
        o_stat.mag_zero   = (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
        o_stat.nrm_hi     = (r_mag[0][55:30] != '0) || (r_mag[1][55:30] != '0)
                            || (r_mag[2][55:30] != '0);
        o_stat.nrm_lo     = !(r_mag[0][29] || r_mag[1][29] || r_mag[2][29]);
        o_stat.sweep_last = (r_sweep == LAST);
    end

    assign o_tdata = r_o_tdata;
    assign o_tuser = r_o_tuser;

endmodule

// ----- sv/vta_ctrl.sv -----
// ----------------------------------------------------------------------------
// Vertex tangent accumulator controller
// Sequences the datapath through the clearing sweep, item decode, face
// arithmetic, normalization, accumulation and the result handoff.
// ----------------------------------------------------------------------------
module vta_ctrl
    import vta_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_SWEEP, S_IDLE, S_DECODE,
        S_DET_A, S_DET_B, S_DET, S_DET_CHK,
        S_VEC_A, S_VEC_B, S_VEC,
        S_NRM_FACE, S_NRM_READ, S_NRM_CHK,
        S_SQ_MUL, S_SQ_ACC, S_SQRT_INIT, S_SQRT,
        S_DIV_INIT, S_DIV, S_DIV_DONE,
        S_ACC_RD, S_ACC_WR, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_lane, n_lane;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    // Next state and datapath command.
    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = DP_NONE;
        o_cmd.lane  = r_lane;
        o_in_ready  = 1'b0;
        case (r_state)
            S_SWEEP: begin
                o_cmd.op = DP_SWEEP;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                n_lane  = 2'd0;
                case (i_stat.opcode)
                    OPC_CORNER: begin
                        if (i_stat.corner == CORNER_0 || i_stat.corner == CORNER_1) begin
                            o_cmd.op = DP_HOLD;
                        end else if (i_stat.corner == CORNER_2) begin
                            n_state = S_DET_A;
                        end
                    end
                    OPC_READ: begin
                        o_cmd.op = DP_VTX_RD;
                        n_state  = S_NRM_READ;
                    end
                    OPC_CLEAR: begin
                        o_cmd.op = DP_CLEAR;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DET_A: begin
                o_cmd.op = DP_MUL_DET_A;
                n_state  = S_DET_B;
            end
            S_DET_B: begin
                o_cmd.op = DP_MUL_DET_B;
                n_state  = S_DET;
            end
            S_DET: begin
                o_cmd.op = DP_DET;
                n_state  = S_DET_CHK;
            end
            S_DET_CHK: begin
                n_state = i_stat.det_zero ? S_OUT : S_VEC_A;
            end
            S_VEC_A: begin
                o_cmd.op = DP_MUL_VEC_A;
                n_state  = S_VEC_B;
            end
            S_VEC_B: begin
                o_cmd.op = DP_MUL_VEC_B;
                n_state  = S_VEC;
            end
            S_VEC: begin
                o_cmd.op = DP_VEC;
                if (r_lane == 2'd2) begin
                    n_lane  = 2'd0;
                    n_state = S_NRM_FACE;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = S_VEC_A;
                end
            end
            S_NRM_FACE: begin
                o_cmd.op = DP_NRM_FACE;
                n_state  = S_NRM_CHK;
            end
            S_NRM_READ: begin
                o_cmd.op = DP_NRM_READ;
                n_state  = S_NRM_CHK;
            end
            // Shift until the largest magnitude has its top bit at bit 29.
            S_NRM_CHK: begin
                n_lane = 2'd0;
                if (i_stat.mag_zero) begin
                    n_state = S_OUT;
                end else if (i_stat.nrm_hi || i_stat.nrm_lo) begin
                    o_cmd.op = DP_NRM_SHIFT;
                end else begin
                    n_state = S_SQ_MUL;
                end
            end
            S_SQ_MUL: begin
                o_cmd.op = DP_MUL_SQ;
                n_state  = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                o_cmd.op = DP_SQ_ACC;
                if (r_lane == 2'd2) begin
                    n_lane  = 2'd0;
                    n_state = S_SQRT_INIT;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQRT_INIT: begin
                o_cmd.op = DP_SQRT_INIT;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = DP_SQRT_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                o_cmd.op = DP_DIV_INIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd17) begin
                    n_state = S_DIV_DONE;
                end
            end
            S_DIV_DONE: begin
                o_cmd.op = DP_DIV_DONE;
                if (r_lane != 2'd2) begin
                    n_lane  = r_lane + 2'd1;
                    n_state = S_DIV_INIT;
                end else begin
                    n_lane  = 2'd0;
                    n_state = (i_stat.opcode == OPC_READ) ? S_OUT : S_ACC_RD;
                end
            end
            // Read-modify-write of each corner's sums in turn.
            S_ACC_RD: begin
                o_cmd.op = DP_ACC_RD;
                n_state  = S_ACC_WR;
            end
            S_ACC_WR: begin
                o_cmd.op = DP_ACC_WR;
                if (r_lane == 2'd2) begin
                    n_lane  = 2'd0;
                    n_state = S_OUT;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = S_ACC_RD;
                end
            end
            // Load the result register once it is free.
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_lane      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/vertex_tangent_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// Vertex tangent accumulator
// Builds per-vertex tangents from streamed triangle corners and returns the
// normalized accumulated tangent of a vertex on request.
// ----------------------------------------------------------------------------
// After reset the block sweeps the tangent sum memory to zero, one entry per
// cycle, and takes no word until that is done. Words are then handled one at a
// time by a shared multiplier, a one-bit-per-cycle square root and a
// one-bit-per-cycle divider. A read or a face passes through one-bit
// normalizing shifts, squaring, the square root and the three divides. A
// degenerate face goes to its result straight after the determinant; a face
// with a zero tangent direction and a read of an empty vertex go to theirs
// straight after normalizing, with no square root or divide. A finished read
// or face waits in its output state while the previous result is still not
// taken. The next word is accepted while the previous result waits.
`include "vertex_tangent_accumulator_top_assert.svh"

module vertex_tangent_accumulator_top
    import vta_pkg::*;
#(
    parameter int MAX_VERTICES = VTA_MAX_VERTICES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // corner, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // degenerate, result_vertex, tangent_x, tangent_y, tangent_z,
    // default_used, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic                 m_axis_tuser
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    vta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    vta_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_stat  (w_stat),
        .o_tdata (m_axis_tdata),
        .o_tuser (m_axis_tuser)
    );

    // While the block is ready, the only datapath command is the input capture.
    `VTA_ASSERT_IMP(a_load_only_when_ready, s_axis_tready, (w_cmd.op == DP_LOAD) || (w_cmd.op == DP_NONE))
    // Loading a result always presents it on the next cycle.
    `VTA_ASSERT_NEXT(a_out_follows_load, w_cmd.op == DP_OUT, m_axis_tvalid)
    // A face result carries only the degenerate flag.
    `VTA_ASSERT_IMP(a_face_fields_zero, m_axis_tvalid && (m_axis_tuser == KIND_FACE), m_axis_tdata[63:1] == '0)

endmodule

// ----- tb/vertex_tangent_accumulator_checker.sv -----
// ----------------------------------------------------------------------------
// Vertex tangent accumulator checker
// Watches both stream channels, keeps its own copy of the per-vertex tangent
// sums, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vertex_tangent_accumulator_checker
    import vta_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [1:0]           i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_m_tuser,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_faces,
    output int                   o_degenerate,
    output int                   o_reads,
    output int                   o_defaults
);

    localparam int SUM_HI = 8388607;
    localparam int SUM_LO = -8388608;
    localparam logic [15:0] Q15_ONE = 16'sd32767;

    typedef struct {
        logic              kind;
        logic              degen;
        logic [11:0]       vertex;
        logic signed [15:0] tan[3];
        logic              dflt;
    } t_tangent_result;

    t_tangent_result result_queue[$];

    // Running tangent sums per vertex and the corners held for the next face.
    int     sum_store[3][VTA_MAX_VERTICES];
    longint held_pos[2][3];
    longint held_uv[2][2];
    int     held_vtx[2];

    initial begin
        o_mismatches = 0;
        o_faces      = 0;
        o_degenerate = 0;
        o_reads      = 0;
        o_defaults   = 0;
        for (int a = 0; a < 3; a++)
            for (int i = 0; i < VTA_MAX_VERTICES; i++)
                sum_store[a][i] = 0;
    end

    assign o_pending = result_queue.size();

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scales the largest magnitude to bit 29, then divides by the rounded-down
    // length with round half up. Returns 0 for a zero vector.
    function automatic bit unit_q15(input longint v[3], output logic signed [15:0] t[3]);
        longint unsigned mag[3];
        longint unsigned mx;
        longint unsigned sq;
        longint unsigned r;
        longint unsigned q;
        int top;
        mx  = 0;
        sq  = 0;
        top = -1;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        if (mx == 0)
            return 1'b0;
        for (int b = 0; b < 64; b++)
            if (mx[b])
                top = b;
        for (int i = 0; i < 3; i++) begin
            if (top > 29)
                mag[i] >>= (top - 29);
            else
                mag[i] <<= (29 - top);
            sq += mag[i] * mag[i];
        end
        r = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 16) + r) / (2 * r);
            if (q > 32767)
                q = 32767;
            t[i] = (v[i] < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
        end
        return 1'b1;
    endfunction

    task automatic add_tangent(input int vtx, input logic signed [15:0] t[3]);
        int s;
        if (vtx >= VTA_MAX_VERTICES)
            return;
        for (int a = 0; a < 3; a++) begin
            s = sum_store[a][vtx] + int'(t[a]);
            if (s > SUM_HI)
                s = SUM_HI;
            if (s < SUM_LO)
                s = SUM_LO;
            sum_store[a][vtx] = s;
        end
    endtask

    // Appends one expected result word at the tail of the queue.
    task automatic enqueue_result(input t_tangent_result r);
        result_queue = {result_queue, r};
    endtask

    // Updates the vertex sums for one accepted word and queues its result.
    task automatic predict_word(input logic [1:0] op, input logic [S_TDATA_W-1:0] d);
        logic [1:0]         corner;
        int                 vtx;
        longint             pos[3];
        longint             tu;
        longint             tv;
        longint             d1u, d1v, d2u, d2v, det;
        longint             vec[3];
        logic signed [15:0] t[3];
        t_tangent_result    res;
        corner = d[1:0];
        vtx    = d[13:2];
        pos[0] = $signed(d[45:14]);
        pos[1] = $signed(d[77:46]);
        pos[2] = $signed(d[109:78]);
        tu     = $signed(d[129:110]);
        tv     = $signed(d[149:130]);
        res.kind   = KIND_FACE;
        res.degen  = 1'b0;
        res.vertex = '0;
        res.dflt   = 1'b0;
        for (int j = 0; j < 3; j++)
            res.tan[j] = '0;
        case (op)
            OPC_CORNER: begin
                if (corner == CORNER_0 || corner == CORNER_1) begin
                    for (int j = 0; j < 3; j++)
                        held_pos[corner][j] = pos[j];
                    held_uv[corner][0] = tu;
                    held_uv[corner][1] = tv;
                    held_vtx[corner]   = vtx;
                end else if (corner == CORNER_2) begin
                    d1u = held_uv[1][0] - held_uv[0][0];
                    d1v = held_uv[1][1] - held_uv[0][1];
                    d2u = tu - held_uv[0][0];
                    d2v = tv - held_uv[0][1];
                    det = d1u * d2v - d2u * d1v;
                    res.degen = (det == 0);
                    if (det != 0) begin
                        for (int j = 0; j < 3; j++) begin
                            vec[j] = d2v * (held_pos[1][j] - held_pos[0][j])
                                   - d1v * (pos[j] - held_pos[0][j]);
                            if (det < 0)
                                vec[j] = -vec[j];
                        end
                        if (unit_q15(vec, t)) begin
                            add_tangent(held_vtx[0], t);
                            add_tangent(held_vtx[1], t);
                            add_tangent(vtx, t);
                        end
                    end
                    o_faces++;
                    if (res.degen)
                        o_degenerate++;
                    enqueue_result(res);
                end
            end
            OPC_READ: begin
                res.kind   = KIND_READ;
                res.vertex = vtx[11:0];
                res.dflt   = 1'b1;
                if (vtx < VTA_MAX_VERTICES) begin
                    for (int j = 0; j < 3; j++)
                        vec[j] = sum_store[j][vtx];
                    if (unit_q15(vec, t)) begin
                        res.dflt = 1'b0;
                        res.tan  = t;
                    end
                end
                if (res.dflt) begin
                    res.tan[0] = Q15_ONE;
                    o_defaults++;
                end
                o_reads++;
                enqueue_result(res);
            end
            OPC_CLEAR: begin
                if (vtx < VTA_MAX_VERTICES)
                    for (int j = 0; j < 3; j++)
                        sum_store[j][vtx] = 0;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        o_mismatches++;
        if (o_mismatches <= 60)
            $display("[%0t] result word mismatch on %s: got %0d, expected %0d",
                     $realtime, field, got, want);
    endtask

    task automatic check_word(input logic kind, input logic [M_TDATA_W-1:0] d);
        t_tangent_result want;
        if (result_queue.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
            return;
        end
        want = result_queue.pop_front();
        if (kind !== want.kind)
            report_mismatch("result_kind", kind, want.kind);
        if (d[0] !== want.degen)
            report_mismatch("degenerate", d[0], want.degen);
        if (d[12:1] !== want.vertex)
            report_mismatch("result_vertex", d[12:1], want.vertex);
        if (d[28:13] !== want.tan[0])
            report_mismatch("tangent_x", $signed(d[28:13]), want.tan[0]);
        if (d[44:29] !== want.tan[1])
            report_mismatch("tangent_y", $signed(d[44:29]), want.tan[1]);
        if (d[60:45] !== want.tan[2])
            report_mismatch("tangent_z", $signed(d[60:45]), want.tan[2]);
        if (d[61] !== want.dflt)
            report_mismatch("default_used", d[61], want.dflt);
    endtask

    // Results are checked before the input of the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready)
                check_word(i_m_tuser, i_m_tdata);
            if (i_s_tvalid && i_s_tready)
                predict_word(i_s_tuser, i_s_tdata);
        end
    end

endmodule

// ----- tb/vertex_tangent_accumulator_top_tb.sv -----
// ----------------------------------------------------------------------------
// Vertex tangent accumulator testbench
// Drives directed and random triangle, read and clear words under varied
// back-pressure; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vertex_tangent_accumulator_top_tb;
    import vta_pkg::*;

    localparam int PHASE_ITEMS = 350;
    localparam int HOLD_CYCLES = 2000;

    // Codes that the block ignores.
    localparam logic [1:0] OPC_UNUSED    = 2'd3;
    localparam logic [1:0] CORNER_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // corner, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // opcode
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // degenerate, result_vertex, tangent_x, tangent_y, tangent_z, default_used
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // result_kind
    logic                 m_axis_tuser;

    int mismatches, pending, faces, degens, reads, defaults;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    bit pressure_go;
    int sent_words;

    vertex_tangent_accumulator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    vertex_tangent_accumulator_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_faces      (faces),
        .o_degenerate (degens),
        .o_reads      (reads),
        .o_defaults   (defaults)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, overridden by the long hold-off.
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off so the block fills up and stalls its input.
    initial begin
        hold_off = 1'b0;
        wait (pressure_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic put_word(input logic [1:0] op, input logic [1:0] corner,
                            input logic [11:0] vtx, input logic [31:0] px,
                            input logic [31:0] py, input logic [31:0] pz,
                            input logic [19:0] tu, input logic [19:0] tv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {2'b00, tv, tu, pz, py, px, vtx, corner};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (op != OPC_UNUSED && !(op == OPC_CORNER && corner == CORNER_UNUSED))
            sent_words++;
    endtask

    function automatic logic [11:0] pick_vertex();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 12'($urandom_range(7));
        if (roll < 90)
            return 12'($urandom);
        return (roll < 95) ? 12'd4095 : 12'd0;
    endfunction

    function automatic logic [31:0] pick_pos();
        if ($urandom_range(1))
            return $urandom;
        return 32'($signed($urandom_range(1048576)) - 524288);
    endfunction

    function automatic logic [19:0] pick_uv();
        if ($urandom_range(1))
            return 20'($urandom);
        return 20'($signed($urandom_range(131072)) - 65536);
    endfunction

    // One triangle: usually random, sometimes a fixed shape that keeps piling
    // the same tangent onto one vertex so its sums saturate.
    task automatic put_triangle();
        logic [19:0] u0, v0, u1, v1, u2, v2;
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            put_word(OPC_CORNER, CORNER_0, 12'd5, 0, 0, 0, '0, '0);
            put_word(OPC_CORNER, CORNER_1, 12'd5, 32'h10000, 0, 0, 20'h10000, '0);
            put_word(OPC_CORNER, CORNER_2, 12'd5, 0, 32'h10000, 0, '0, 20'h10000);
        end else if (roll < 18) begin
            put_word(OPC_CORNER, CORNER_0, 12'd6, 0, 0, 0, '0, '0);
            put_word(OPC_CORNER, CORNER_1, 12'd6, -32'sh10000, 0, 0, 20'h10000, '0);
            put_word(OPC_CORNER, CORNER_2, 12'd6, 0, 32'h10000, 0, '0, 20'h10000);
        end else begin
            u0 = pick_uv(); v0 = pick_uv();
            u1 = pick_uv(); v1 = pick_uv();
            u2 = pick_uv(); v2 = pick_uv();
            // Some faces reuse a texture coordinate so the determinant is zero.
            if (roll < 28) begin
                u2 = u0;
                v2 = v0;
            end
            put_word(OPC_CORNER, CORNER_0, pick_vertex(), pick_pos(), pick_pos(),
                     pick_pos(), u0, v0);
            put_word(OPC_CORNER, CORNER_1, pick_vertex(), pick_pos(), pick_pos(),
                     pick_pos(), u1, v1);
            put_word(OPC_CORNER, CORNER_2, pick_vertex(), pick_pos(), pick_pos(),
                     pick_pos(), u2, v2);
        end
    endtask

    // Mostly whole triangles, then reads, clears, noise and broken sequences.
    task automatic random_phase(input int idle_pct, input int stall_pct);
        int stop_at;
        int roll;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = sent_words + PHASE_ITEMS;
        while (sent_words < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 62)
                put_triangle();
            else if (roll < 80)
                put_word(OPC_READ, 2'($urandom), pick_vertex(), $urandom, $urandom,
                         $urandom, 20'($urandom), 20'($urandom));
            else if (roll < 83)
                put_word(OPC_CLEAR, 2'($urandom), pick_vertex(), $urandom, $urandom,
                         $urandom, 20'($urandom), 20'($urandom));
            else if (roll < 89)
                put_word(OPC_UNUSED, 2'($urandom), 12'($urandom), $urandom, $urandom,
                         $urandom, 20'($urandom), 20'($urandom));
            else
                put_word(OPC_CORNER, 2'($urandom), pick_vertex(), pick_pos(),
                         pick_pos(), pick_pos(), pick_uv(), pick_uv());
        end
    endtask

    initial begin
        int waited;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go    = 1'b0;
        sent_words     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: plain face, degenerate face, flat face, repeated vertex,
        // field extremes, reads of filled and empty vertices, clear, ignored words.
        put_word(OPC_CORNER, CORNER_0, 12'd0, 0, 0, 0, '0, '0);
        put_word(OPC_CORNER, CORNER_1, 12'd1, 32'h10000, 0, 0, 20'h10000, '0);
        put_word(OPC_CORNER, CORNER_2, 12'd2, 0, 32'h10000, 0, '0, 20'h10000);
        put_word(OPC_CORNER, CORNER_2, 12'd2, 5, 6, 7, '0, '0);
        put_word(OPC_CORNER, CORNER_0, 12'd3, 32'h1234, 32'h1234, 32'h1234, '0, '0);
        put_word(OPC_CORNER, CORNER_1, 12'd3, 32'h1234, 32'h1234, 32'h1234, 20'h100, '0);
        put_word(OPC_CORNER, CORNER_2, 12'd3, 32'h1234, 32'h1234, 32'h1234, '0, 20'h100);
        put_word(OPC_CORNER, CORNER_0, 12'd4095, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 20'h80000, 20'h7ffff);
        put_word(OPC_CORNER, CORNER_1, 12'd4095, 32'h7fffffff, 32'h80000000,
                 32'hffffffff, 20'h7ffff, 20'h80000);
        put_word(OPC_CORNER, CORNER_2, 12'd4095, 32'h7fffffff, 32'h7fffffff,
                 32'h00000000, 20'h80000, 20'h80000);
        put_word(OPC_READ, CORNER_0, 12'd0, 0, 0, 0, '0, '0);
        put_word(OPC_READ, CORNER_0, 12'd3, 0, 0, 0, '0, '0);
        put_word(OPC_READ, CORNER_UNUSED, 12'd4095, '1, '1, '1, '1, '1);
        put_word(OPC_READ, CORNER_0, 12'd100, 0, 0, 0, '0, '0);
        put_word(OPC_CLEAR, CORNER_0, 12'd0, 0, 0, 0, '0, '0);
        put_word(OPC_READ, CORNER_0, 12'd0, 0, 0, 0, '0, '0);
        put_word(OPC_CLEAR, CORNER_0, 12'd4095, 0, 0, 0, '0, '0);
        put_word(OPC_READ, CORNER_0, 12'd4095, 0, 0, 0, '0, '0);
        put_word(OPC_UNUSED, CORNER_2, 12'd1, '1, '1, '1, '1, '1);
        put_word(OPC_CORNER, CORNER_UNUSED, 12'd1, '1, '1, '1, '1, '1);

        random_phase(0, 0);
        random_phase(75, 0);
        random_phase(0, 75);
        random_phase(19, 19);
        pressure_go = 1'b1;
        random_phase(0, 0);
        s_axis_tvalid <= 1'b0;

        // Drain, then let the last word settle.
        waited = 0;
        while (pending != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (400) @(posedge i_clk);

        $display("Covered %0d faces (%0d with zero UV determinant) and %0d reads",
                 faces, degens, reads);
        $display("(%0d returning the default tangent), with and without back-pressure.",
                 defaults);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
